>>> design/cdo_pkg.sv
// Shared types, constants and calendar helper functions for the date offset core.
// Used by cdo_step, calendar_date_day_offset_core and cdo_checker.
`timescale 1ns / 1ps

package cdo_pkg;

  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 21;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ACC_W   = OFFSET_BITS + 2;
  localparam int R400_W  = 9;

  localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);

  localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] CYCLE_Y  = YEAR_W'(400);
  localparam logic [R400_W-1:0] R400_TOP = R400_W'(399);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // one pass of the month walk
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [R400_W-1:0]  r400;
    logic [ACC_W-1:0]   dacc;
    logic               done;
    logic               err;
  } step_t;

  // leap year from year mod 400
  function automatic logic is_leap(input logic [R400_W-1:0] r400);
    logic century;
    century = (r400 == R400_W'(100)) || (r400 == R400_W'(200)) ||
              (r400 == R400_W'(300));
    return (r400[1:0] == 2'b00) && !century;
  endfunction

  // month length, 0 for codes that are not a month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

>>> design/cdo_step.sv
// Month walk unit: one carry or borrow of whole months on the day accumulator.
// Depends on cdo_pkg.
`timescale 1ns / 1ps

module cdo_step
  import cdo_pkg::*;
(
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [R400_W-1:0]  r400_i,
  input  logic [ACC_W-1:0]   dacc_i,
  output step_t              step_o
);

  logic               leap;
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   prev_len;
  logic [MONTH_W-1:0] prev_m;
  logic signed [ACC_W-1:0] acc_s;
  logic signed [ACC_W-1:0] cur_s;
  logic signed [ACC_W-1:0] prev_s;
  logic over;
  logic under;

  assign leap     = is_leap(r400_i);
  assign cur_len  = month_len(month_i, leap);
  assign prev_m   = (month_i == JANUARY) ? DECEMBER : month_i - MONTH_W'(1);
  assign prev_len = month_len(prev_m, leap);
  assign acc_s    = $signed(dacc_i);
  assign cur_s    = $signed({{(ACC_W-DAY_W){1'b0}}, cur_len});
  assign prev_s   = $signed({{(ACC_W-DAY_W){1'b0}}, prev_len});
  assign over     = acc_s > cur_s;
  assign under    = acc_s < $signed(ACC_W'(1));

  always_comb begin
    step_o       = '0;
    step_o.year  = year_i;
    step_o.month = month_i;
    step_o.r400  = r400_i;
    step_o.dacc  = dacc_i;
    step_o.done  = !over && !under;
    if (over) begin
      step_o.dacc = ACC_W'(acc_s - cur_s);
      if (month_i == DECEMBER) begin
        if (year_i == YEAR_MAX) begin
          step_o.err  = 1'b1;
          step_o.done = 1'b1;
        end else begin
          step_o.year  = year_i + YEAR_W'(1);
          step_o.month = JANUARY;
          step_o.r400  = (r400_i == R400_TOP) ? '0 : r400_i + R400_W'(1);
        end
      end else begin
        step_o.month = month_i + MONTH_W'(1);
      end
    end else if (under) begin
      // step back first, then add the length of the month stepped into
      step_o.dacc  = ACC_W'(acc_s + prev_s);
      step_o.month = prev_m;
      if (month_i == JANUARY) begin
        if (year_i == YEAR_MIN) begin
          step_o.err  = 1'b1;
          step_o.done = 1'b1;
        end else begin
          step_o.year = year_i - YEAR_W'(1);
          step_o.r400 = (r400_i == '0) ? R400_TOP : r400_i - R400_W'(1);
        end
      end
    end
  end

endmodule

>>> design/calendar_date_day_offset_core.sv
// Gregorian date plus signed day offset, top level with sequencer and result register.
// Depends on cdo_pkg and cdo_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a start date and a signed day offset.
//   Result channel (out_valid/out_ready) returns the shifted date and an error flag;
//   on error the date fields read zero.
//   One transaction is in flight at a time: in_ready is high only while idle.
//   The sequencer reduces the start year mod 400 by repeated subtraction, checks
//   the date, then walks the day accumulator month by month through the single
//   month step unit and registers the result.
//   A full-scale offset of 2^20 days crosses about 34,500 months.
//   An invalid start date goes straight from the check to the result, without a walk.
//   The result holds in its register while the receiver stalls; no new input is
//   taken until it is accepted.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.

`timescale 1ns / 1ps

module calendar_date_day_offset_core
  import cdo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [YEAR_W-1:0]      in_start_year,
  input  logic [MONTH_W-1:0]     in_start_month,
  input  logic [DAY_W-1:0]       in_start_day,
  input  logic [OFFSET_BITS-1:0] in_offset_days,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [YEAR_W-1:0]      out_result_year,
  output logic [MONTH_W-1:0]     out_result_month,
  output logic [DAY_W-1:0]       out_result_day,
  output logic                   out_error
);

  state_t state_r, state_nxt;

  logic [YEAR_W-1:0]      year_r, year_nxt;
  logic [MONTH_W-1:0]     month_r, month_nxt;
  logic [DAY_W-1:0]       day_r, day_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [YEAR_W-1:0]      rem_r, rem_nxt;
  logic [R400_W-1:0]      r400_r, r400_nxt;
  logic [ACC_W-1:0]       dacc_r, dacc_nxt;
  logic                   err_r, err_nxt;

  step_t            step;
  logic             start_ok;
  logic [DAY_W-1:0] start_len;

  cdo_step u_step (
    .year_i  (year_r),
    .month_i (month_r),
    .r400_i  (r400_r),
    .dacc_i  (dacc_r),
    .step_o  (step)
  );

  assign start_len = month_len(month_r, is_leap(r400_r));
  assign start_ok  = (year_r >= YEAR_MIN) && (year_r <= YEAR_MAX) &&
                     (month_r >= JANUARY) && (month_r <= DECEMBER) &&
                     (day_r != '0) && (day_r <= start_len);

  always_comb begin
    state_nxt = state_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    r400_nxt  = r400_r;
    dacc_nxt  = dacc_r;
    err_nxt   = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          year_nxt  = in_start_year;
          month_nxt = in_start_month;
          day_nxt   = in_start_day;
          off_nxt   = in_offset_days;
          rem_nxt   = in_start_year;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_r >= CYCLE_Y) begin
          rem_nxt = rem_r - CYCLE_Y;
        end else begin
          r400_nxt  = rem_r[R400_W-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dacc_nxt = ACC_W'($signed({{(ACC_W-DAY_W){1'b0}}, day_r}) +
                          $signed({{(ACC_W-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r}));
        if (start_ok) begin
          state_nxt = ST_WALK;
        end else begin
          err_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_WALK: begin
        year_nxt  = step.year;
        month_nxt = step.month;
        r400_nxt  = step.r400;
        dacc_nxt  = step.dacc;
        err_nxt   = step.err;
        if (step.done) begin
          day_nxt   = dacc_r[DAY_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          err_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    off_r   <= off_nxt;
    rem_r   <= rem_nxt;
    r400_r  <= r400_nxt;
    dacc_r  <= dacc_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = (state_r == ST_OUT);
  assign out_error        = err_r;
  assign out_result_year  = err_r ? '0 : year_r;
  assign out_result_month = err_r ? '0 : month_r;
  assign out_result_day   = err_r ? '0 : day_r;

endmodule

>>> design/cdo_checker.sv
// Port-level checker for calendar_date_day_offset_core, attached by bind.
// Depends on cdo_pkg.
`timescale 1ns / 1ps

module cdo_props
  import cdo_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [YEAR_W-1:0]      out_result_year,
  input logic [MONTH_W-1:0]     out_result_month,
  input logic [DAY_W-1:0]       out_result_day,
  input logic                   out_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_year) &&
      $stable(out_result_month) && $stable(out_result_day) && $stable(out_error))
    else $error("result changed while stalled");

  // one transaction in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_result_year == '0 && out_result_month == '0 &&
      out_result_day == '0)
    else $error("error result carries a date");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_result_year >= YEAR_MIN &&
      out_result_year <= YEAR_MAX && out_result_month >= JANUARY &&
      out_result_month <= DECEMBER && out_result_day != '0)
    else $error("result date out of range");

endmodule

bind calendar_date_day_offset_core cdo_props u_cdo_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_error        (out_error)
);

>>> test/cdo_checker.sv
// Checker for calendar_date_day_offset_core: watches both channels, predicts each result
// from the accepted start date and offset, and compares field by field. Depends on cdo_pkg.
`timescale 1ns / 1ps

module cdo_checker
  import cdo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [YEAR_W-1:0]      in_start_year,
  input  logic [MONTH_W-1:0]     in_start_month,
  input  logic [DAY_W-1:0]       in_start_day,
  input  logic [OFFSET_BITS-1:0] in_offset_days,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [YEAR_W-1:0]      out_result_year,
  input  logic [MONTH_W-1:0]     out_result_month,
  input  logic [DAY_W-1:0]       out_result_day,
  input  logic                   out_error,
  output int                     mismatches,
  output int                     pending,
  output int                     checked,
  output int                     flagged
);

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               err;
  } cal_date_t;

  cal_date_t dates_due[$];
  int        fail_cnt = 0;
  int        result_cnt = 0;
  int        err_cnt = 0;

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in(input longint y, input longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // days elapsed since 1 January of year 1
  function automatic longint day_serial(input longint y, input longint m, input longint d);
    longint n;
    longint py;
    py = y - 1;
    n = 365 * py + py / 4 - py / 100 + py / 400;
    for (longint k = 1; k < m; k++) n += days_in(y, k);
    return n + d - 1;
  endfunction

  function automatic cal_date_t shift_date(input logic [YEAR_W-1:0] y,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [DAY_W-1:0] d,
                                           input logic [OFFSET_BITS-1:0] off);
    cal_date_t r;
    longint    yy, mm, dd, n, last, delta;
    r = '0;
    r.err = 1'b1;
    yy = y;
    mm = m;
    dd = d;
    delta = $signed(off);
    if (yy < 1 || yy > MAX_YEAR || mm < 1 || mm > 12 || dd < 1 || dd > days_in(yy, mm))
      return r;
    n = day_serial(yy, mm, dd) + delta;
    last = day_serial(MAX_YEAR, 12, 31);
    if (n < 0 || n > last)
      return r;
    // n/366 never overshoots the year, walk up from there
    yy = n / 366 + 1;
    while (day_serial(yy + 1, 1, 1) <= n) yy++;
    n -= day_serial(yy, 1, 1);
    mm = 1;
    while (n >= days_in(yy, mm)) begin
      n -= days_in(yy, mm);
      mm++;
    end
    r.year  = YEAR_W'(yy);
    r.month = MONTH_W'(mm);
    r.day   = DAY_W'(n + 1);
    r.err   = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    cal_date_t want;
    bit        bad;
    if (rst_n) begin
      if (in_valid && in_ready)
        dates_due.push_back(shift_date(in_start_year, in_start_month, in_start_day,
                                       in_offset_days));
      if (out_valid && out_ready) begin
        result_cnt++;
        if (out_error) err_cnt++;
        if (dates_due.size() == 0) begin
          if (fail_cnt < 10)
            $display("result %0d arrived with nothing outstanding: %0d-%0d-%0d err=%0b",
                     result_cnt, out_result_year, out_result_month, out_result_day,
                     out_error);
          fail_cnt++;
        end else begin
          want = dates_due.pop_front();
          bad = (out_result_year !== want.year) || (out_result_month !== want.month) ||
                (out_result_day !== want.day) || (out_error !== want.err);
          if (bad) begin
            if (fail_cnt < 10)
              $display("mismatch on result %0d: expected %0d-%0d-%0d err=%0b,",
                       result_cnt, want.year, want.month, want.day, want.err,
                       " got %0d-%0d-%0d err=%0b",
                       out_result_year, out_result_month, out_result_day, out_error);
            fail_cnt++;
          end
        end
      end
    end
    pending    <= dates_due.size();
    mismatches <= fail_cnt;
    checked    <= result_cnt;
    flagged    <= err_cnt;
  end

endmodule

>>> test/calendar_date_day_offset_core_test.sv
// Top of the date offset testbench: clock, reset, stimulus and verdict.
// Depends on cdo_pkg, calendar_date_day_offset_core and cdo_checker.
`timescale 1ns / 1ps

module calendar_date_day_offset_core_test;
  import cdo_pkg::*;

  localparam int RANDOM_ITEMS = 80;
  localparam int HOLD_CYCLES  = 400;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [YEAR_W-1:0]      in_start_year = '0;
  logic [MONTH_W-1:0]     in_start_month = '0;
  logic [DAY_W-1:0]       in_start_day = '0;
  logic [OFFSET_BITS-1:0] in_offset_days = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [YEAR_W-1:0]      out_result_year;
  logic [MONTH_W-1:0]     out_result_month;
  logic [DAY_W-1:0]       out_result_day;
  logic                   out_error;

  logic calm = 1'b0;      // no idling on either side while set
  logic hold_req = 1'b0;  // asks the receiver for one long hold-off
  int   mismatches, pending, checked, flagged;
  int   sent = 0;

  always #5 clk = ~clk;

  calendar_date_day_offset_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_offset_days  (in_offset_days),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_year (out_result_year),
    .out_result_month(out_result_month),
    .out_result_day  (out_result_day),
    .out_error       (out_error)
  );

  cdo_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_offset_days  (in_offset_days),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_year (out_result_year),
    .out_result_month(out_result_month),
    .out_result_day  (out_result_day),
    .out_error       (out_error),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .flagged         (flagged)
  );

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 26);
    end
  end

  // valid stays up across back-to-back transactions; it only drops for a gap or a drain
  task automatic offer_date(input int y, input int m, input int d, input int off);
    int gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= YEAR_W'(y);
    in_start_month <= MONTH_W'(m);
    in_start_day   <= DAY_W'(d);
    in_offset_days <= OFFSET_BITS'(off);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int y, m, d, off, pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: leap rules, field extremes, range edges, full-scale offsets
    offer_date(2024, 2, 29, 0);
    offer_date(2023, 2, 29, 0);
    offer_date(1900, 2, 29, 5);
    offer_date(2000, 2, 29, 365);
    offer_date(0, 1, 1, 10);
    offer_date(16383, 15, 31, -1);
    offer_date(9999, 12, 31, 0);
    offer_date(9999, 12, 31, 1);
    offer_date(1, 1, 1, -1);
    offer_date(1, 1, 1, 0);
    offer_date(1, 1, 1, 1048575);
    offer_date(9999, 12, 31, -1048576);
    offer_date(2020, 0, 15, 3);
    offer_date(2020, 13, 15, 3);
    offer_date(2020, 5, 0, 3);
    offer_date(2021, 4, 31, 1);
    offer_date(2021, 1, 31, 29);
    offer_date(2024, 3, 1, -1);
    offer_date(1600, 3, 1, -1);
    offer_date(1999, 12, 31, 1);
    offer_date(2000, 1, 1, -1);
    offer_date(2021, 6, 10, -1);
    offer_date(5000, 6, 15, -1048576);
    offer_date(8000, 1, 1, 1048575);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 25) hold_req <= 1'b1;
      if (i == 45) calm <= 1'b1;
      if (i == 60) calm <= 1'b0;
      if (i == 65) drain_results();
      if ($urandom_range(0, 99) < 10) begin
        // raw fields, mostly invalid dates
        y = $urandom_range(0, 16383);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
        off = $urandom();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       y = $urandom_range(1, 3);
        else if (pick < 16) y = $urandom_range(9997, 9999);
        else if (pick < 26) y = 100 * $urandom_range(1, 99);
        else                y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        // days past 28 may overrun a short month on purpose
        d = ($urandom_range(0, 99) < 15) ? $urandom_range(29, 31) : $urandom_range(1, 28);
        pick = $urandom_range(0, 99);
        if (pick < 60)      off = $urandom_range(0, 800) - 400;
        else if (pick < 85) off = $urandom_range(0, 40000) - 20000;
        else if (pick < 92) off = $urandom();
        else                off = $urandom_range(0, 62) - 31;
      end
      offer_date(y, m, d, off);
    end
    drain_results();
    repeat (200) @(posedge clk);

    $display("Ran %0d transactions: directed leap, range and field-edge dates plus random",
             sent);
    $display("dates and offsets; %0d results checked, %0d flagged as errors", checked,
             flagged);
    if (mismatches == 0)
      $display("[calendar_date_day_offset_core] OK");
    else
      $display("[calendar_date_day_offset_core] ERROR");
    $finish;
  end

  initial begin
    #250_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("[calendar_date_day_offset_core] ERROR");
    $finish;
  end

endmodule

>>> calendar_date_day_offset_core.f
design/cdo_pkg.sv
design/cdo_step.sv
design/calendar_date_day_offset_core.sv
design/cdo_checker.sv
test/cdo_checker.sv
test/calendar_date_day_offset_core_test.sv
